/* hdl/prwd_pkg.sv */
// shared types and codes for the pixel readout word decoder
// word type codes, result kinds and the result payload struct; no dependencies
package prwd_pkg;

  localparam int WORD_W = 32;

  // top byte codes of non-hit words
  localparam logic [7:0] TYPE_CHIP_TIME  = 8'h40;
  localparam logic [7:0] TYPE_TRIG_LOW   = 8'h10;
  localparam logic [7:0] TYPE_TRIG_HIGH  = 8'h30;
  localparam logic [7:0] TYPE_BOARD_MID  = 8'h20;
  localparam logic [7:0] TYPE_BOARD_END  = 8'h60;
  localparam logic [7:0] TYPE_OVERFLOW   = 8'h01;
  localparam logic [7:0] TYPE_BUSY       = 8'h02;
  localparam logic [7:0] TYPE_T0         = 8'h70;
  localparam logic [7:0] TYPE_LOCK_LOST  = 8'h0C;
  localparam logic [7:0] TYPE_LOCK_EST   = 8'h08;
  localparam logic [7:0] TYPE_WEIRD      = 8'h04;

  typedef enum logic [2:0] {
    KIND_HIT       = 3'd0,
    KIND_OVERFLOW  = 3'd1,
    KIND_BUSY      = 3'd2,
    KIND_T0        = 3'd3,
    KIND_LOCK_LOST = 3'd4,
    KIND_LOCK_EST  = 3'd5,
    KIND_WEIRD     = 3'd6,
    KIND_UNKNOWN   = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [4:0]   column;
    logic [8:0]   pixel_row;
    logic [9:0]   coarse_time;
    logic [5:0]   fine_time;
    logic [5:0]   over_threshold;
    logic [63:0]  board_time;
    logic [31:0]  trigger_number;
    logic [15:0]  chip_time;
    logic [23:0]  event_value;
  } result_t;

endpackage

/* hdl/prwd_in_reg.sv */
// input register of the pixel readout word decoder
// holds one readout word until the core takes it; uses prwd_pkg
module prwd_in_reg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [prwd_pkg::WORD_W-1:0] in_word,
  input  logic                        take,
  output logic                        valid,
  output logic [prwd_pkg::WORD_W-1:0] word
);
  import prwd_pkg::*;

  logic              valid_r, valid_nxt;
  logic [WORD_W-1:0] word_r;
  logic              load;

  assign in_ready = !valid_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      word_r <= in_word;
    end
  end

  assign valid = valid_r;
  assign word  = word_r;

endmodule

/* hdl/prwd_core.sv */
// decode logic and timestamp / trigger state of the pixel readout word decoder
// unpacks one word per cycle while fire is high and then updates the stored counters; uses prwd_pkg
module prwd_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [prwd_pkg::WORD_W-1:0] word,
  output logic                        emit,
  output prwd_pkg::result_t           res
);
  import prwd_pkg::*;

  logic [31:0] trig_r, trig_nxt;
  logic [15:0] bt_high_r, bt_high_nxt;
  logic [23:0] bt_mid_r, bt_mid_nxt;
  logic [23:0] bt_low_r, bt_low_nxt;
  logic [63:0] bt_full_r, bt_full_nxt;
  logic [15:0] chip_r, chip_nxt;
  logic [7:0]  top_byte;
  logic [23:0] low24;
  logic [5:0]  lead;

  assign top_byte = word[31:24];
  assign low24    = word[23:0];
  assign lead     = {word[10:6], 1'b0};

  always_comb begin
    trig_nxt    = trig_r;
    bt_high_nxt = bt_high_r;
    bt_mid_nxt  = bt_mid_r;
    bt_low_nxt  = bt_low_r;
    bt_full_nxt = bt_full_r;
    chip_nxt    = chip_r;
    emit        = 1'b1;
    res         = '0;
    res.kind    = KIND_UNKNOWN;
    if (word[31]) begin
      res.kind           = KIND_HIT;
      res.column         = word[29:25];
      res.pixel_row      = word[24:16];
      res.coarse_time    = word[15:6];
      res.fine_time      = word[5:0];
      res.over_threshold = word[5:0] - lead;
      res.board_time     = bt_full_r;
      res.trigger_number = trig_r;
      res.chip_time      = chip_r;
    end else begin
      case (top_byte)
        TYPE_CHIP_TIME: begin
          chip_nxt = word[23:8];
          emit     = 1'b0;
        end
        TYPE_TRIG_LOW: begin
          trig_nxt = {8'd0, low24};
          emit     = 1'b0;
        end
        TYPE_TRIG_HIGH: begin
          trig_nxt    = trig_r + {word[23:16], 24'd0};
          bt_high_nxt = word[15:0];
          emit        = 1'b0;
        end
        TYPE_BOARD_MID: begin
          bt_mid_nxt = low24;
          emit       = 1'b0;
        end
        TYPE_BOARD_END: begin
          bt_low_nxt  = low24;
          bt_full_nxt = {bt_high_r, bt_mid_r, low24};
          emit        = 1'b0;
        end
        TYPE_OVERFLOW:  res.kind = KIND_OVERFLOW;
        TYPE_BUSY: begin
          res.kind        = KIND_BUSY;
          res.event_value = low24;
        end
        TYPE_T0: begin
          bt_high_nxt     = '0;
          bt_mid_nxt      = '0;
          bt_low_nxt      = low24;
          bt_full_nxt     = {40'd0, low24};
          res.kind        = KIND_T0;
          res.event_value = low24;
        end
        TYPE_LOCK_LOST: res.kind = KIND_LOCK_LOST;
        TYPE_LOCK_EST:  res.kind = KIND_LOCK_EST;
        TYPE_WEIRD:     res.kind = KIND_WEIRD;
        default:        res.kind = KIND_UNKNOWN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r    <= '0;
      bt_high_r <= '0;
      bt_mid_r  <= '0;
      bt_low_r  <= '0;
      bt_full_r <= '0;
      chip_r    <= '0;
    end else if (fire) begin
      trig_r    <= trig_nxt;
      bt_high_r <= bt_high_nxt;
      bt_mid_r  <= bt_mid_nxt;
      bt_low_r  <= bt_low_nxt;
      bt_full_r <= bt_full_nxt;
      chip_r    <= chip_nxt;
    end
  end

endmodule

/* hdl/prwd_out_reg.sv */
// result register of the pixel readout word decoder
// holds one decoded beat until the receiver takes it; uses prwd_pkg
module prwd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  prwd_pkg::result_t res_in,
  input  logic              out_ready,
  output logic              room,
  output logic              valid,
  output prwd_pkg::result_t res_q
);
  import prwd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign room = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid = valid_r;
  assign res_q = res_r;

endmodule

/* hdl/pixel_readout_word_decoder_top.sv */
// top level of the pixel readout word decoder
// input register, decode core and result register; uses prwd_pkg and the prwd_* modules
//
// usage
//   in_* channel: one 32-bit readout word per beat (valid/ready)
//   out_* channel: one decoded beat per hit, event or unrecognised word (valid/ready)
//   words that only update stored state (chip time, trigger low/high,
//   board time middle/end) produce no output beat
// timing
//   a word accepted into the input register is decoded from there, and its
//   result beat is loaded into the result register, which presents it
//   throughput is one word per cycle while the receiver does not stall, set
//   by the single decode stage between the input register and the result register
// stall
//   when the receiver holds out_ready low the result register keeps its
//   beat, the decode stage waits and the input register still takes one
//   more word if it was empty; after that in_ready drops until the result drains
// reset
//   rst_n is synchronous, active low; it empties both registers and
//   clears trigger count, board timestamp parts and chip timestamp
module pixel_readout_word_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [4:0]  out_column,
  output logic [8:0]  out_pixel_row,
  output logic [9:0]  out_coarse_time,
  output logic [5:0]  out_fine_time,
  output logic [5:0]  out_over_threshold,
  output logic [63:0] out_board_time,
  output logic [31:0] out_trigger_number,
  output logic [15:0] out_chip_time,
  output logic [23:0] out_event_value
);
  import prwd_pkg::*;

  logic              word_valid;
  logic [WORD_W-1:0] word;
  logic              room;
  logic              fire;
  logic              emit;
  result_t           res;
  result_t           res_q;

  // a word moves into decode whenever the result register can take a beat
  assign fire = word_valid && room;

  prwd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .take     (fire),
    .valid    (word_valid),
    .word     (word)
  );

  prwd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .word  (word),
    .emit  (emit),
    .res   (res)
  );

  // silent update words pass through decode without loading a beat
  prwd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && emit),
    .res_in    (res),
    .out_ready (out_ready),
    .room      (room),
    .valid     (out_valid),
    .res_q     (res_q)
  );

  assign out_kind           = res_q.kind;
  assign out_column         = res_q.column;
  assign out_pixel_row      = res_q.pixel_row;
  assign out_coarse_time    = res_q.coarse_time;
  assign out_fine_time      = res_q.fine_time;
  assign out_over_threshold = res_q.over_threshold;
  assign out_board_time     = res_q.board_time;
  assign out_trigger_number = res_q.trigger_number;
  assign out_chip_time      = res_q.chip_time;
  assign out_event_value    = res_q.event_value;

endmodule
